// File: hdl/ipv4ap_pkg.sv
`timescale 1ns / 1ps

package ipv4ap_pkg;

  // default pool size
  localparam int POOL_DEPTH_DEF = 64;

  localparam int ADDR_W   = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD     = 2'd0,
    CMD_ALLOCATE = 2'd1,
    CMD_RELEASE  = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_EMPTY         = 2'd1,
    ST_NOT_ALLOCATED = 2'd2,
    ST_FULL          = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_AFETCH = 6'b000010,
    S_AGRANT = 6'b000100,
    S_SCAN   = 6'b001000,
    S_RFREE  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

endpackage

// File: hdl/ipv4_address_pool_allocator.sv
`timescale 1ns / 1ps

// IPv4 address pool with a FIFO free list.
// Input channel (in_valid/in_ready) carries command and address; output channel
// (out_valid/out_ready) carries status and granted_address, one result per command.
// load appends the address to the next unused entry and to the free tail
// (status full when the pool is full); allocate pops the oldest free entry,
// marks it and returns its address (status empty and 0 when none is free);
// release searches the loaded entries for an allocated one holding the address
// and returns it to the free tail (status not allocated otherwise).
// One command at a time: in_ready is high only while the sequencer is idle.
// out_valid rises once S_DONE loads the output register: for load, the unused
// code and early errors straight after the input transfer, for allocate after the
// S_AFETCH and S_AGRANT steps and for release after S_SCAN, in which the single
// comparator walks the entry memory one entry per cycle, and S_RFREE on a hit.
// The output register lets the next command be taken while a result waits;
// a stalled receiver holds the following result in its final step, so no
// result is lost or reordered.
// Reset (rst, synchronous) empties the pool and free list; entry contents are
// not cleared, since the load count bounds every read.

module ipv4_address_pool_allocator
  import ipv4ap_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [ADDR_W-1:0]   address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [ADDR_W-1:0]   granted_address
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(POOL_DEPTH);
  localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(POOL_DEPTH - 1);

  // entry memory: allocated mark over address
  logic [ADDR_W:0]    entry_mem [POOL_DEPTH];
  logic [IDX_W-1:0]   free_queue [POOL_DEPTH];

  logic [ADDR_W:0]    mem_q;
  logic [IDX_W-1:0]   fq_q;

  state_t             state, state_next;
  logic [IDX_W-1:0]   free_head, free_head_next;
  logic [IDX_W-1:0]   free_tail, free_tail_next;
  logic [CNT_W-1:0]   free_count, free_count_next;
  logic [CNT_W-1:0]   loaded_count, loaded_count_next;
  logic [ADDR_W-1:0]  addr_r, addr_r_next;
  logic [CNT_W-1:0]   scan_i, scan_i_next;
  logic [IDX_W-1:0]   look_i, look_i_next;
  logic               look_v, look_v_next;
  logic [IDX_W-1:0]   hit_i, hit_i_next;
  status_t            res_status, res_status_next;
  logic [ADDR_W-1:0]  res_granted, res_granted_next;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [ADDR_W:0]    mem_wd;
  logic [IDX_W-1:0]   rd_addr;
  logic               fq_we;
  logic [IDX_W-1:0]   fq_wa;
  logic [IDX_W-1:0]   fq_wd;

  assign in_ready = (state == S_IDLE);

  // sequencer and shared comparator
  always_comb begin
    state_next        = state;
    free_head_next    = free_head;
    free_tail_next    = free_tail;
    free_count_next   = free_count;
    loaded_count_next = loaded_count;
    addr_r_next       = addr_r;
    scan_i_next       = scan_i;
    look_i_next       = look_i;
    look_v_next       = 1'b0;
    hit_i_next        = hit_i;
    res_status_next   = res_status;
    res_granted_next  = res_granted;
    mem_we            = 1'b0;
    mem_wa            = '0;
    mem_wd            = '0;
    fq_we             = 1'b0;
    fq_wa             = free_tail;
    fq_wd             = '0;
    rd_addr           = scan_i[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          addr_r_next      = address;
          res_status_next  = ST_OK;
          res_granted_next = '0;
          state_next       = S_DONE;
          case (cmd_t'(command))
            CMD_LOAD: begin
              if (loaded_count == DEPTH_C || free_count == DEPTH_C) begin
                res_status_next = ST_FULL;
              end else begin
                mem_we            = 1'b1;
                mem_wa            = loaded_count[IDX_W-1:0];
                mem_wd            = {1'b0, address};
                fq_we             = 1'b1;
                fq_wd             = loaded_count[IDX_W-1:0];
                free_tail_next    = (free_tail == LAST_C) ? '0 : free_tail + 1'b1;
                free_count_next   = free_count + 1'b1;
                loaded_count_next = loaded_count + 1'b1;
              end
            end
            CMD_ALLOCATE: begin
              if (free_count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                state_next = S_AFETCH;
              end
            end
            CMD_RELEASE: begin
              if (loaded_count == '0) begin
                res_status_next = ST_NOT_ALLOCATED;
              end else begin
                scan_i_next = '0;
                state_next  = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      // head slot has been read, fetch the entry it names
      S_AFETCH: begin
        rd_addr    = fq_q;
        state_next = S_AGRANT;
      end

      // mark the entry allocated and hand out its address
      S_AGRANT: begin
        mem_we           = 1'b1;
        mem_wa           = fq_q;
        mem_wd           = {1'b1, mem_q[ADDR_W-1:0]};
        res_granted_next = mem_q[ADDR_W-1:0];
        free_head_next   = (free_head == LAST_C) ? '0 : free_head + 1'b1;
        free_count_next  = free_count - 1'b1;
        state_next       = S_DONE;
      end

      // one read issued and one entry compared per cycle
      S_SCAN: begin
        if (scan_i < loaded_count) begin
          look_v_next = 1'b1;
          look_i_next = scan_i[IDX_W-1:0];
          scan_i_next = scan_i + 1'b1;
        end
        if (look_v && mem_q[ADDR_W] && mem_q[ADDR_W-1:0] == addr_r) begin
          hit_i_next  = look_i;
          look_v_next = 1'b0;
          state_next  = S_RFREE;
        end else if (look_v && (CNT_W'(look_i) + CNT_W'(1)) == loaded_count) begin
          res_status_next = ST_NOT_ALLOCATED;
          look_v_next     = 1'b0;
          state_next      = S_DONE;
        end
      end

      // clear the mark and push the entry onto the free tail if the free list has room
      S_RFREE: begin
        if (free_count < DEPTH_C) begin
          mem_we          = 1'b1;
          mem_wa          = hit_i;
          mem_wd          = {1'b0, addr_r};
          fq_we           = 1'b1;
          fq_wd           = hit_i;
          free_tail_next  = (free_tail == LAST_C) ? '0 : free_tail + 1'b1;
          free_count_next = free_count + 1'b1;
        end else begin
          res_status_next = ST_NOT_ALLOCATED;
        end
        state_next = S_DONE;
      end

      // wait for the output register to be free
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_head    <= '0;
      free_tail    <= '0;
      free_count   <= '0;
      loaded_count <= '0;
      look_v       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      free_head    <= free_head_next;
      free_tail    <= free_tail_next;
      free_count   <= free_count_next;
      loaded_count <= loaded_count_next;
      look_v       <= look_v_next;
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r      <= addr_r_next;
    scan_i      <= scan_i_next;
    look_i      <= look_i_next;
    hit_i       <= hit_i_next;
    res_status  <= res_status_next;
    res_granted <= res_granted_next;
    if (state == S_DONE && (!out_valid || out_ready)) begin
      status          <= res_status;
      granted_address <= res_granted;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= mem_wd;
    end
    mem_q <= entry_mem[rd_addr];
  end

  // free queue memory, written at the tail and read at the head
  always_ff @(posedge clk) begin
    if (fq_we) begin
      free_queue[fq_wa] <= fq_wd;
    end
    fq_q <= free_queue[free_head];
  end

  // checks
  a_free_le_loaded: assert property (@(posedge clk) disable iff (rst)
    free_count <= loaded_count)
    else $error("free count exceeds loaded count");

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= DEPTH_C)
    else $error("loaded count beyond pool depth");

  a_grant_pops: assert property (@(posedge clk) disable iff (rst)
    state == S_AGRANT |=> free_count == $past(free_count) - 1'b1)
    else $error("allocate did not pop the free list");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in progress");

  a_scan_only_release: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> loaded_count != '0)
    else $error("scan started on an empty pool");

endmodule

// File: dv/ipv4ap_pool_checker.sv
`timescale 1ns / 1ps

module ipv4ap_pool_checker
  import ipv4ap_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [ADDR_W-1:0]   address,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] status,
  input  logic [ADDR_W-1:0]   granted_address,
  output int unsigned         mismatch_count,
  output int unsigned         awaited_count
);

  localparam int unsigned POOL_DEPTH = POOL_DEPTH_DEF;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] granted;
  } pool_response_t;

  // shadow copy of the pool and its free ring
  logic [ADDR_W-1:0] pool_addr [POOL_DEPTH];
  bit                pool_taken [POOL_DEPTH];
  int unsigned       free_ring [POOL_DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_tail;
  int unsigned       n_free;
  int unsigned       n_loaded;

  pool_response_t awaited_responses [$];
  int unsigned    bad_results;

  assign mismatch_count = bad_results;
  assign awaited_count  = awaited_responses.size();

  function automatic int unsigned ring_next(input int unsigned pos);
    return (pos + 1 >= POOL_DEPTH) ? 0 : pos + 1;
  endfunction

  task automatic push_free_entry(input int unsigned idx);
    free_ring[ring_tail] = idx;
    ring_tail = ring_next(ring_tail);
    n_free++;
  endtask

  // work out the response to one command and update the shadow pool
  task automatic predict_pool_response(input cmd_t op, input logic [ADDR_W-1:0] addr,
                                       output pool_response_t resp);
    int unsigned idx;
    int unsigned i;
    bit          hit;
    resp.status  = ST_OK;
    resp.granted = '0;
    hit = 1'b0;
    idx = 0;
    case (op)
      CMD_LOAD: begin
        if (n_loaded >= POOL_DEPTH || n_free >= POOL_DEPTH) begin
          resp.status = ST_FULL;
        end else begin
          pool_addr[n_loaded]  = addr;
          pool_taken[n_loaded] = 1'b0;
          push_free_entry(n_loaded);
          n_loaded++;
        end
      end
      CMD_ALLOCATE: begin
        if (n_free == 0) begin
          resp.status = ST_EMPTY;
        end else begin
          idx = free_ring[ring_head];
          ring_head = ring_next(ring_head);
          n_free--;
          pool_taken[idx] = 1'b1;
          resp.granted = pool_addr[idx];
        end
      end
      CMD_RELEASE: begin
        // lowest-indexed allocated entry holding the address
        for (i = 0; i < n_loaded; i++) begin
          if (!hit && pool_taken[i] && pool_addr[i] == addr) begin
            hit = 1'b1;
            idx = i;
          end
        end
        if (hit && n_free < POOL_DEPTH) begin
          pool_taken[idx] = 1'b0;
          push_free_entry(idx);
        end else begin
          resp.status = ST_NOT_ALLOCATED;
        end
      end
      default: begin
        // unused code leaves the pool alone
      end
    endcase
  endtask

  task automatic log_bad_result(input string what);
    bad_results++;
    if (bad_results <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // compare results against the oldest prediction, then predict new commands
  always @(posedge clk) begin
    pool_response_t want;
    pool_response_t fresh;
    if (rst) begin
      for (int unsigned j = 0; j < POOL_DEPTH; j++) begin
        pool_taken[j] = 1'b0;
      end
      ring_head = 0;
      ring_tail = 0;
      n_free    = 0;
      n_loaded  = 0;
      awaited_responses.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_responses.size() == 0) begin
          log_bad_result($sformatf("result with no command pending: status %0d granted %h",
                                   status, granted_address));
        end else begin
          want = awaited_responses.pop_front();
          if (status !== want.status || granted_address !== want.granted) begin
            log_bad_result($sformatf("status exp %0d got %0d, granted exp %h got %h",
                                     want.status, status, want.granted, granted_address));
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_pool_response(cmd_t'(command), address, fresh);
        awaited_responses.push_back(fresh);
      end
    end
  end

  initial begin
    bad_results = 0;
  end

endmodule

// File: dv/tb_ipv4_address_pool_allocator.sv
`timescale 1ns / 1ps

module tb_ipv4_address_pool_allocator;
  import ipv4ap_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1300;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 120;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned IDLE_PCT       = 29;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    command   = CMD_LOAD;
  logic [ADDR_W-1:0]   address   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   granted_address;

  int unsigned mismatch_count;
  int unsigned awaited_count;
  int unsigned quiet_cycles = 0;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  // addresses that went into the pool, used to aim releases and duplicate loads
  logic [ADDR_W-1:0] loaded_addrs [$];

  ipv4_address_pool_allocator dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .address         (address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_address (granted_address)
  );

  ipv4ap_pool_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .address         (address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_address (granted_address),
    .mismatch_count  (mismatch_count),
    .awaited_count   (awaited_count)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // offer one command and wait for its transfer
  task automatic issue_command(input cmd_t op, input logic [ADDR_W-1:0] addr);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= op;
    address  <= addr;
    do @(posedge clk); while (!in_ready);
    if (op == CMD_LOAD && loaded_addrs.size() < POOL_DEPTH_DEF) begin
      loaded_addrs.push_back(addr);
    end
  endtask

  function automatic logic [ADDR_W-1:0] pick_loaded();
    return loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
  endfunction

  initial begin
    int unsigned       k;
    int unsigned       r;
    logic [ADDR_W-1:0] a;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty pool, unused code, address extremes and duplicates
    issue_command(CMD_ALLOCATE, 32'h1234_5678);
    issue_command(CMD_RELEASE,  32'h0000_0000);
    issue_command(CMD_UNUSED,   32'hFFFF_FFFF);
    issue_command(CMD_LOAD,     32'h0000_0000);
    issue_command(CMD_LOAD,     32'hFFFF_FFFF);
    issue_command(CMD_LOAD,     32'hC0A8_0001);
    issue_command(CMD_LOAD,     32'hC0A8_0001);
    issue_command(CMD_LOAD,     32'h8000_0001);
    issue_command(CMD_ALLOCATE, 32'hFFFF_FFFF);
    issue_command(CMD_ALLOCATE, 32'h0000_0000);
    issue_command(CMD_ALLOCATE, 32'hAAAA_AAAA);
    issue_command(CMD_ALLOCATE, 32'h5555_5555);
    issue_command(CMD_RELEASE,  32'hC0A8_0001);
    issue_command(CMD_RELEASE,  32'hFFFF_FFFF);
    issue_command(CMD_RELEASE,  32'hFFFF_FFFF);
    issue_command(CMD_RELEASE,  32'h8000_0001);
    issue_command(CMD_ALLOCATE, 32'h0000_0000);
    issue_command(CMD_ALLOCATE, 32'h0000_0000);
    issue_command(CMD_ALLOCATE, 32'h0000_0000);
    issue_command(CMD_ALLOCATE, 32'h0000_0000);
    issue_command(CMD_RELEASE,  32'h0000_0000);
    issue_command(CMD_RELEASE,  32'hC0A8_0001);
    issue_command(CMD_RELEASE,  32'hC0A8_0001);
    issue_command(CMD_UNUSED,   32'h5A5A_5A5A);
    issue_command(CMD_ALLOCATE, 32'hFFFF_FFFF);

    // random traffic, releases mostly aimed at loaded addresses so they hit
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 700 && k < 900);
      if (k == 300) begin
        hold_req = 1'b1;
      end
      r = $urandom_range(99);
      a = $urandom;
      if (r < 18) begin
        if (loaded_addrs.size() != 0 && $urandom_range(3) == 0) begin
          a = pick_loaded();
        end
        issue_command(CMD_LOAD, a);
      end else if (r < 55) begin
        issue_command(CMD_ALLOCATE, a);
      end else if (r < 93) begin
        if (loaded_addrs.size() != 0 && $urandom_range(3) != 0) begin
          a = pick_loaded();
        end
        issue_command(CMD_RELEASE, a);
      end else begin
        issue_command(CMD_UNUSED, a);
      end
    end
    in_valid <= 1'b0;

    // drain outstanding results, then allow for any stray one
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: ipv4_address_pool_allocator.f
hdl/ipv4ap_pkg.sv
hdl/ipv4_address_pool_allocator.sv
dv/ipv4ap_pool_checker.sv
dv/tb_ipv4_address_pool_allocator.sv
